// File: hdl/edq_pkg.sv
// Shared types, constants and helpers for the RGB error-diffusion quantizer.
// Used by edq_ctrl, edq_chan, edq_dp and the top level; no dependencies.
package edq_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int FILL_W = COL_W + 1;
   localparam int ERR_W = 30;
   localparam int NUM_CH = 3;

   // Register indexes on the csr port
   localparam logic [1:0] REG_RED_COUNT = 2'd0;
   localparam logic [1:0] REG_GREEN_COUNT = 2'd1;
   localparam logic [1:0] REG_BLUE_COUNT = 2'd2;
   localparam logic [1:0] REG_LINE_WIDTH = 2'd3;

   // x / 255 == (x * DIV255_MUL) >> 23 for any 16-bit x
   localparam logic [31:0] DIV255_MUL = 32'h0000_8081;

   localparam logic signed [35:0] ERR_MAX = 36'sd536870911;
   localparam logic signed [35:0] ERR_MIN = -36'sd536870912;

   typedef struct packed {
      logic accept;
      logic sum_en;
      logic mul_en;
      logic shade_en;
      logic level_en;
      logic err_en;
      logic finish;
      logic wr_cur;
   } edq_cmd_type;

   typedef struct packed {
      logic out_free;
   } edq_status_type;

   typedef logic [7:0] scale_table_type [256];

   // scale = 255 div steps, built at elaboration from products only
   function automatic scale_table_type build_scale_table();
      scale_table_type t;
      int q;
      for (int s = 0; s < 256; s++) begin
         q = 0;
         for (int k = 1; k < 256; k++) begin
            if (k * s <= 255) begin
               q = k;
            end
         end
         t[s] = 8'(q);
      end
      return t;
   endfunction

   localparam scale_table_type SCALE_TABLE = build_scale_table();

   function automatic logic [ERR_W-1:0] sat30(input logic signed [35:0] v);
      logic [ERR_W-1:0] r;
      if (v > ERR_MAX) begin
         r = ERR_MAX[ERR_W-1:0];
      end else if (v < ERR_MIN) begin
         r = ERR_MIN[ERR_W-1:0];
      end else begin
         r = v[ERR_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/edq_ctrl.sv
// Sequencer for the quantizer: walks one item through the datapath steps.
// Depends on edq_pkg for the command and status structs.
module edq_ctrl
   import edq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  edq_status_type status,
   output edq_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SUM   = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SHADE = 3'd3;
   localparam logic [2:0] ST_LEVEL = 3'd4;
   localparam logic [2:0] ST_ERR   = 3'd5;
   localparam logic [2:0] ST_PREV  = 3'd6;
   localparam logic [2:0] ST_CUR   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      cmd.accept   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.sum_en   = (state_ff == ST_SUM);
      cmd.mul_en   = (state_ff == ST_MUL);
      cmd.shade_en = (state_ff == ST_SHADE);
      cmd.level_en = (state_ff == ST_LEVEL);
      cmd.err_en   = (state_ff == ST_ERR);
      cmd.finish   = (state_ff == ST_PREV) && status.out_free;
      cmd.wr_cur   = (state_ff == ST_CUR);
   end

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = req_tvalid ? ST_SUM : ST_IDLE;
         ST_SUM:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_SHADE;
         ST_SHADE: state_in = ST_LEVEL;
         ST_LEVEL: state_in = ST_ERR;
         ST_ERR:   state_in = ST_PREV;
         ST_PREV:  state_in = status.out_free ? ST_CUR : ST_PREV;
         ST_CUR:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/edq_chan.sv
// One color channel: sum, quantize, error split and the channel's row buffer.
// Depends on edq_pkg for the scale table, sat30 and command struct.
module edq_chan
   import edq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  edq_cmd_type      cmd,
   input  logic             frame_start,
   input  logic             row_end,
   input  logic [7:0]       sample,
   input  logic [COL_W-1:0] rd_addr,
   input  logic [COL_W-1:0] col,
   input  logic             above_ok,
   input  logic [7:0]       steps,
   output logic [7:0]       level,
   output logic [7:0]       shade
);

   logic [ERR_W-1:0] row_mem [MAX_WIDTH];

   logic [7:0]         sample_ff;
   logic [ERR_W-1:0]   rd_data_ff;
   logic signed [31:0] sum_ff;
   logic [15:0]        prod_ff;
   logic [7:0]         shade_ff;
   logic [7:0]         level_ff;
   logic signed [32:0] err_ff;
   logic signed [32:0] e1_ff;
   logic [ERR_W-1:0]   ahead_ff;
   logic [ERR_W-1:0]   br_ff;
   logic [ERR_W-1:0]   pend_ff;

   logic signed [31:0] above;
   logic signed [31:0] sum_in;
   logic [7:0]         clamped;
   logic [15:0]        div_arg;
   logic [31:0]        div_prod;
   logic [15:0]        lvl_prod;
   logic [7:0]         scale;
   logic signed [32:0] err_in;
   logic signed [32:0] e1_in;
   logic signed [35:0] e1x;
   logic signed [35:0] errx;
   logic signed [35:0] e3;
   logic signed [35:0] e5;
   logic signed [35:0] e7;
   logic [ERR_W-1:0]   prev_val;
   logic [ERR_W-1:0]   cur_val;
   logic               wr_en;
   logic [COL_W-1:0]   wr_addr;
   logic [ERR_W-1:0]   wr_data;

   assign above = above_ok ? {{(32-ERR_W){rd_data_ff[ERR_W-1]}}, rd_data_ff} : 32'sd0;
   assign sum_in = $signed({24'd0, sample_ff}) + above
                 + $signed({{(32-ERR_W){ahead_ff[ERR_W-1]}}, ahead_ff});

   always_comb begin
      if (sum_ff[31]) begin
         clamped = 8'd0;
      end else if (sum_ff > 32'sd255) begin
         clamped = 8'd255;
      end else begin
         clamped = sum_ff[7:0];
      end
   end

   // shade = (prod + 127) div 255, same as (2*v*steps + 255) div 510
   assign div_arg  = prod_ff + 16'd127;
   assign div_prod = {16'd0, div_arg} * DIV255_MUL;
   assign scale    = SCALE_TABLE[steps];
   assign lvl_prod = {8'd0, shade_ff} * {8'd0, scale};

   assign err_in = {sum_ff[31], sum_ff} - $signed({25'd0, level_ff});
   // truncate toward zero
   assign e1_in  = (err_in + (err_in[32] ? 33'sd15 : 33'sd0)) >>> 4;

   assign e1x  = {{3{e1_ff[32]}}, e1_ff};
   assign errx = {{3{err_ff[32]}}, err_ff};
   assign e3   = (e1x <<< 1) + e1x;
   assign e5   = (e1x <<< 2) + e1x;
   assign e7   = errx - ((e1x <<< 3) + e1x);

   assign prev_val = sat30({{(36-ERR_W){pend_ff[ERR_W-1]}}, pend_ff} + e3);
   assign cur_val  = sat30({{(36-ERR_W){br_ff[ERR_W-1]}}, br_ff} + e5);

   assign wr_en   = (cmd.finish && (col != '0)) || cmd.wr_cur;
   assign wr_addr = cmd.wr_cur ? col : col - 1'b1;
   assign wr_data = cmd.wr_cur ? pend_ff : prev_val;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_data_ff <= row_mem[rd_addr];
      end
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample;
      end
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= {8'd0, clamped} * {8'd0, steps};
      end
      if (cmd.shade_en) begin
         shade_ff <= div_prod[30:23];
      end
      if (cmd.level_en) begin
         level_ff <= (lvl_prod > 16'd255) ? 8'd255 : lvl_prod[7:0];
      end
      if (cmd.err_en) begin
         err_ff <= err_in;
         e1_ff  <= e1_in;
      end
      // below term for the current column, stored on the next step
      if (cmd.finish) begin
         pend_ff <= cur_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_ff <= '0;
         br_ff    <= '0;
      end else if (cmd.accept && frame_start) begin
         ahead_ff <= '0;
         br_ff    <= '0;
      end else if (cmd.finish) begin
         ahead_ff <= sat30(e7);
         br_ff    <= sat30(e1x);
      end else if (cmd.wr_cur && row_end) begin
         ahead_ff <= '0;
         br_ff    <= '0;
      end
   end

   assign level = level_ff;
   assign shade = shade_ff;

endmodule

// File: hdl/edq_dp.sv
// Datapath: config registers, column and row-buffer fill tracking, three
// channel units and the output register. Depends on edq_pkg and edq_chan.
module edq_dp
   import edq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  edq_cmd_type    cmd,
   output edq_status_type status,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [10:0]    csr_wdata,
   input  logic [23:0]    req_tdata,
   input  logic           req_tuser,
   input  logic           rsp_tready,
   output logic           rsp_tvalid,
   output logic [47:0]    rsp_tdata
);

   logic [8:0]        count_ff [NUM_CH];
   logic [10:0]       line_width_ff;
   logic [COL_W-1:0]  column_ff;
   logic              first_row_ff;
   logic              above_ok_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              rsp_valid_ff;
   logic [47:0]       rsp_data_ff;

   logic [COL_W-1:0]  col_eff;
   logic              first_eff;
   logic [10:0]       width_eff;
   logic              row_end;
   logic [7:0]        steps  [NUM_CH];
   logic [7:0]        level  [NUM_CH];
   logic [7:0]        shade  [NUM_CH];
   logic [47:0]       rsp_data_in;

   assign col_eff   = req_tuser ? '0 : column_ff;
   assign first_eff = req_tuser | first_row_ff;

   always_comb begin
      if (line_width_ff == 11'd0) begin
         width_eff = 11'd1;
      end else if (line_width_ff > 11'(MAX_WIDTH)) begin
         width_eff = 11'(MAX_WIDTH);
      end else begin
         width_eff = line_width_ff;
      end
   end

   assign row_end = (11'(column_ff) + 11'd1) >= width_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            count_ff[i] <= 9'd2;
         end
         line_width_ff <= 11'(MAX_WIDTH);
      end else if (csr_we) begin
         case (csr_index)
            REG_RED_COUNT:   count_ff[0] <= csr_wdata[8:0];
            REG_GREEN_COUNT: count_ff[1] <= csr_wdata[8:0];
            REG_BLUE_COUNT:  count_ff[2] <= csr_wdata[8:0];
            REG_LINE_WIDTH:  line_width_ff <= csr_wdata;
            default:         line_width_ff <= line_width_ff;
         endcase
      end
   end

   // Row buffer entries at or above fill_ff were never written: read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
         above_ok_ff  <= 1'b0;
         fill_ff      <= '0;
      end else if (cmd.accept) begin
         column_ff    <= col_eff;
         first_row_ff <= first_eff;
         above_ok_ff  <= !first_eff && (FILL_W'(col_eff) < fill_ff);
      end else if (cmd.wr_cur) begin
         if (FILL_W'(column_ff) == fill_ff) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (row_end) begin
            column_ff    <= '0;
            first_row_ff <= 1'b0;
         end else begin
            column_ff <= column_ff + 1'b1;
         end
      end
   end

   for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
      always_comb begin
         if (count_ff[g] < 9'd2) begin
            steps[g] = 8'd1;
         end else if (count_ff[g] > 9'd256) begin
            steps[g] = 8'd255;
         end else begin
            steps[g] = 8'(count_ff[g] - 9'd1);
         end
      end

      edq_chan u_chan (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .frame_start (req_tuser),
         .row_end     (row_end),
         .sample      (req_tdata[8*g +: 8]),
         .rd_addr     (col_eff),
         .col         (column_ff),
         .above_ok    (above_ok_ff),
         .steps       (steps[g]),
         .level       (level[g]),
         .shade       (shade[g])
      );
   end

   assign rsp_data_in = {shade[2], shade[1], shade[0], level[2], level[1], level[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/rgb_error_diffusion_quantizer_top.sv
// RGB error-diffusion quantizer, top level.
// Input stream (req_): one raster-order RGB pixel per item, tuser marks the
// first pixel of a frame. Output stream (rsp_): quantized level and shade
// number per channel, one item for every input item, in order.
// Config port (csr_): shade counts per channel and the line width, written
// while the block is idle; values out of range are clamped.
// Timing: an item runs the SUM, MUL, SHADE, LEVEL, ERR, PREV and CUR steps
// before the next item is accepted; its result shows on rsp_tvalid after
// the PREV step. One item is in flight at a time; the single-port row
// buffer (one read, up to two writes per pixel) and the multiplies set that.
// Reset: synchronous; shade counts return to 2, line width to 1024, the
// first row after reset reads no error from above. No clearing pass is
// needed: a fill count marks row-buffer entries never written.
// Stall: while rsp_tready is low the result holds in the output register;
// the next item is still accepted and runs up to the output step, where it
// waits until the register is free.
// Depends on edq_pkg, edq_ctrl and edq_dp.
module rgb_error_diffusion_quantizer_top
   import edq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // red_level, green_level, blue_level,
                                    // red_shade, green_shade, blue_shade
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   edq_cmd_type    cmd;
   edq_status_type status;

   edq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   edq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // one datapath step at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   // only one item in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in flight");

   // result loads only into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwrote a pending output item");

   // a new result appears exactly after a finish step
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.finish))
      else $error("rsp_tvalid rose without a finished item");

endmodule
